[rtl/dtc_pkg.sv]
// dtc_pkg: shared constants and helpers for the decimal text to cents parser
`default_nettype none

package dtc_pkg;

  // magnitude limit and widths of the accumulator paths
  localparam int unsigned MAG_W  = 63;
  localparam int unsigned WIDE_W = 68;
  localparam logic [WIDE_W-1:0] MAG_MAX = {{(WIDE_W-MAG_W){1'b0}}, {MAG_W{1'b1}}};

  // default number of fraction digits kept
  localparam int unsigned DEFAULT_FRACTION_DIGITS = 2;
  localparam int unsigned MAX_FRACTION_DIGITS     = 3;

  // character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MALFORMED = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;

  // digit times ten to the power n, n no larger than MAX_FRACTION_DIGITS
  function automatic logic [WIDE_W-1:0] digit_place(input logic [3:0] d, input int unsigned n);
    logic [WIDE_W-1:0] v;
    v = {{(WIDE_W-4){1'b0}}, d};
    for (int unsigned k = 0; k < MAX_FRACTION_DIGITS; k++) begin
      if (k < n) begin
        v = (v << 3) + (v << 1);
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/decimal_text_to_cents_parser_core.sv]
// decimal_text_to_cents_parser_core: character stream to signed hundredths (by default)
//
// Takes one character per transfer and, on an end-of-text transfer, gives one
// result: the signed amount in units of 10^-FRACTION_DIGITS and a status (ok,
// malformed, overflow). Each transfer is registered, then handled by a
// multiply-by-ten accumulate with a range compare, so one character is taken
// every cycle when not stalled; an end-of-text transfer passes the input and
// result registers in turn. The amount is kept scaled to the output unit, so the
// end of text needs only a sign change. The block stalls its input only while a
// result is held back by the output and a further end-of-text waits behind it.
`default_nettype none

module decimal_text_to_cents_parser_core #(
  parameter int unsigned FRACTION_DIGITS = dtc_pkg::DEFAULT_FRACTION_DIGITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [7:0]          in_char_code,
  input  wire                 in_end_of_text,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [63:0]  out_amount_cents,
  output dtc_pkg::status_t    out_status
);
  import dtc_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRACTION_DIGITS + 1);

  // parse phase codes
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_WHOLE = 3'd1;
  localparam logic [2:0] PH_FRAC  = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_ERROR = 3'd4;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;

  // parse state
  logic [2:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] cents_r, cents_nxt;
  logic [CNT_W-1:0] frac_cnt_r, frac_cnt_nxt;
  logic             digit_seen_r, digit_seen_nxt;
  logic             ovf_r, ovf_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic signed [63:0]  out_amount_r, out_amount_nxt;
  status_t             out_status_r, out_status_nxt;

  logic in_acc, out_free, s1_go, s1_char_go, s1_eot_go;
  logic is_digit;
  logic [3:0] digit;
  logic [WIDE_W-1:0] whole_sum, frac_sum;
  logic [63:0] mag64;

  // handshake
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_go      = s1_valid_r && (!s1_eot_r || out_free);
  assign s1_char_go = s1_go && !s1_eot_r;
  assign s1_eot_go  = s1_go && s1_eot_r;
  assign in_stall   = s1_valid_r && !s1_go;
  assign in_acc     = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !s1_go);

  // digit decode and candidate sums
  assign is_digit  = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign digit     = 4'(s1_char_r - CH_ZERO);
  assign whole_sum = ({{(WIDE_W-MAG_W){1'b0}}, cents_r} << 3)
                   + ({{(WIDE_W-MAG_W){1'b0}}, cents_r} << 1)
                   + digit_place(digit, FRACTION_DIGITS);
  assign frac_sum  = {{(WIDE_W-MAG_W){1'b0}}, cents_r}
                   + digit_place(digit, FRACTION_DIGITS - 1 - int'(frac_cnt_r));

  // next parse state
  always_comb begin
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    cents_nxt      = cents_r;
    frac_cnt_nxt   = frac_cnt_r;
    digit_seen_nxt = digit_seen_r;
    ovf_nxt        = ovf_r;
    if (s1_eot_go) begin
      phase_nxt      = PH_START;
      neg_nxt        = 1'b0;
      cents_nxt      = '0;
      frac_cnt_nxt   = '0;
      digit_seen_nxt = 1'b0;
      ovf_nxt        = 1'b0;
    end else if (s1_char_go) begin
      unique case (phase_r)
        PH_START, PH_WHOLE: begin
          if (phase_r == PH_START && s1_char_r == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_WHOLE;
          end else if (s1_char_r == CH_DOT) begin
            phase_nxt = PH_FRAC;
          end else if (s1_char_r == CH_COMMA) begin
            phase_nxt = PH_SKIP;
          end else if (is_digit) begin
            phase_nxt      = PH_WHOLE;
            digit_seen_nxt = 1'b1;
            if (!ovf_r) begin
              if (whole_sum > MAG_MAX) begin
                ovf_nxt = 1'b1;
              end else begin
                cents_nxt = MAG_W'(whole_sum);
              end
            end
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_FRAC: begin
          if (!is_digit) begin
            phase_nxt = PH_ERROR;
          end else begin
            digit_seen_nxt = 1'b1;
            if (frac_cnt_r < CNT_W'(FRACTION_DIGITS)) begin
              frac_cnt_nxt = frac_cnt_r + 1'b1;
              if (!ovf_r) begin
                if (frac_sum > MAG_MAX) begin
                  ovf_nxt = 1'b1;
                end else begin
                  cents_nxt = MAG_W'(frac_sum);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result formation
  assign mag64 = {1'b0, cents_r};
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_amount_nxt = out_amount_r;
    out_status_nxt = out_status_r;
    if (s1_eot_go) begin
      out_valid_nxt = 1'b1;
      if (phase_r == PH_ERROR || !digit_seen_r) begin
        out_status_nxt = ST_MALFORMED;
        out_amount_nxt = '0;
      end else if (ovf_r) begin
        out_status_nxt = ST_OVERFLOW;
        out_amount_nxt = '0;
      end else begin
        out_status_nxt = ST_OK;
        out_amount_nxt = neg_r ? -$signed(mag64) : $signed(mag64);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_START;
      neg_r        <= 1'b0;
      cents_r      <= '0;
      frac_cnt_r   <= '0;
      digit_seen_r <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      phase_r      <= phase_nxt;
      neg_r        <= neg_nxt;
      cents_r      <= cents_nxt;
      frac_cnt_r   <= frac_cnt_nxt;
      digit_seen_r <= digit_seen_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_code;
      s1_eot_r  <= in_end_of_text;
    end
    out_amount_r <= out_amount_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_amount_cents = out_amount_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

[rtl/dtc_checker.sv]
// dtc_checker: port-level checks for the parser core, with its bind
`default_nettype none

module dtc_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input wire signed [63:0]  out_amount_cents,
  input wire [1:0]          out_status
);
  import dtc_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_amount_cents) && $stable(out_status))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MALFORMED
                   || out_status == ST_OVERFLOW))
    else $error("undefined status code");

  // failed parse gives amount zero
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_amount_cents == 64'sd0)
    else $error("non-zero amount with failing status");

  // a good amount never reaches the most negative code
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_amount_cents != {1'b1, 63'd0})
    else $error("amount out of range");

endmodule

bind decimal_text_to_cents_parser_core dtc_checker u_dtc_checker (.*);

`default_nettype wire
